### hdl/hnht_pkg.sv
// Package for the hashed next-hop table: sizes, request and row types, back-end states.
// Depends on nothing; every other file of the block imports it.
package hnht_pkg;

    // Table geometry. SLOTS is a power of two of at least two, WAYS at least one.
    localparam int SLOTS    = 16;
    localparam int WAYS     = 4;
    localparam int NODE_W   = 8;
    localparam int BUCKET_W = $clog2(SLOTS);

    // Depth of the queue between the front and the back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes as they arrive on the request channel.
    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic {
        OP_SET,
        OP_GET
    } t_op;

    // A classified request as it waits in the queue.
    typedef struct packed {
        t_op                 op;
        logic [BUCKET_W-1:0] bucket;
        logic [NODE_W-1:0]   dest;
        logic [NODE_W-1:0]   next;
    } t_req;

    // Head of the queue as the back end sees it.
    typedef struct packed {
        logic vld;
        t_req req;
    } t_q_head;

    // One way of a bucket and one whole bucket row of the store.
    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [NODE_W-1:0] next;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef enum logic {
        BK_READ,
        BK_CMP
    } t_back_state;

endpackage

### hdl/hnht_if.sv
// Request and result channel interfaces of the hashed next-hop table.
// Depends on hnht_pkg for the field widths.
interface hnht_in_if;
    import hnht_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [NODE_W-1:0] dest_node;
    logic [NODE_W-1:0] next_node;

    modport source (output valid, command, dest_node, next_node, input ready);
    modport sink   (input valid, command, dest_node, next_node, output ready);
endinterface

interface hnht_out_if;
    import hnht_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [NODE_W-1:0] next_hop;
    logic              bucket_full;

    modport source (output valid, found, next_hop, bucket_full, input ready);
    modport sink   (input valid, found, next_hop, bucket_full, output ready);
endinterface

### hdl/hashed_next_hop_table_top.sv
// Top level of the hashed next-hop table: front end, request queue and back end.
// Depends on hnht_pkg, hnht_if, hnht_front and hnht_back.
//
// The block maps an 8-bit destination node to an 8-bit next hop. A request with
// command 0 sets the next hop of a destination and one with command 1 looks it
// up; each request gives exactly one result. The bucket of a destination is its
// low bits (destination modulo SLOTS) and each bucket has WAYS entries. A set
// updates the entry that already holds the destination, or else takes the
// lowest free way; when the destination is new and the bucket is full the set
// is refused and bucket_full is raised. A lookup that misses returns found = 0
// and next_hop = 0. Reset empties the table at once through per-entry valid
// flops, so the block is ready as soon as reset is released. The front end
// takes a request whenever its two-entry queue has room, even while a result
// waits on the output. For each request the back end first reads the bucket
// row from the single-port row memory, then compares the ways, writes the row
// back and loads the result register. It takes no new request until that
// read, compare and write-back loop is done; a stalled result channel holds
// the back end in its compare state. When nothing stalls, a request passes
// through the queue, the row read register and the result register before
// its result is presented.
module hashed_next_hop_table_top
    import hnht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hnht_in_if.sink    i_req,
    hnht_out_if.source o_rsp
);

    // Queue head offered to the back end, and the back end's pop when done.
    t_q_head head;
    logic    pop;

    hnht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    hnht_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

### hdl/hnht_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on hnht_pkg and hnht_in_if.
module hnht_front
    import hnht_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hnht_in_if.sink       i_req,
    output t_q_head       o_head,
    input  logic          i_pop
);

    t_req              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    t_req              cls;

    // Decode the command and split off the bucket index.
    always_comb begin
        cls.bucket = i_req.dest_node[BUCKET_W-1:0];
        cls.dest   = i_req.dest_node;
        cls.next   = i_req.next_node;
        unique case (i_req.command)
            CMD_SET: cls.op = OP_SET;
            CMD_GET: cls.op = OP_GET;
            default: cls.op = OP_GET;
        endcase
    end

    assign i_req.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign push        = i_req.valid && i_req.ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    assign o_head.vld = (r_cnt != '0);
    assign o_head.req = r_q[r_rptr];

endmodule

### hdl/hnht_back.sv
// Back end: bucket row memory, valid bits, compare and write-back, result register.
// Depends on hnht_pkg and hnht_out_if.
module hnht_back
    import hnht_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_head       i_head,
    output logic          o_pop,
    hnht_out_if.source    o_rsp
);

    t_row              mem [SLOTS];
    t_row              r_rd_row;
    logic [WAYS-1:0]   r_valid [SLOTS];
    t_back_state       r_state, n_state;

    logic              rd_en;
    logic              wr_en;
    t_row              wr_row;
    logic [WAYS-1:0]   vrow, n_vrow;
    logic [WAYS-1:0]   match, hit_oh, freev, free_oh;
    logic [NODE_W-1:0] hop;
    logic              any_hit, any_free, out_free;

    logic              r_ovalid;
    logic              r_found, n_found;
    logic [NODE_W-1:0] r_hop, n_hop;
    logic              r_full, n_full;

    assign vrow     = r_valid[i_head.req.bucket];
    assign out_free = !r_ovalid || o_rsp.ready;

    // Way compare; the lowest set bit wins for both hit and free way.
    always_comb begin
        hop = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = vrow[w] && (r_rd_row[w].dest == i_head.req.dest);
            freev[w] = !vrow[w];
        end
        hit_oh  = match & (~match + 1'b1);
        free_oh = freev & (~freev + 1'b1);
        for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
                hop = hop | r_rd_row[w].next;
            end
        end
        any_hit  = |match;
        any_free = |freev;
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        o_pop   = 1'b0;
        wr_row  = r_rd_row;
        n_vrow  = vrow;
        n_found = any_hit;
        n_hop   = '0;
        n_full  = 1'b0;
        if (i_head.req.op == OP_GET) begin
            n_hop = any_hit ? hop : '0;
        end else begin
            n_full = !any_hit && !any_free;
            for (int w = 0; w < WAYS; w++) begin
                if (any_hit) begin
                    if (hit_oh[w]) begin
                        wr_row[w].next = i_head.req.next;
                    end
                end else if (free_oh[w]) begin
                    wr_row[w].dest = i_head.req.dest;
                    wr_row[w].next = i_head.req.next;
                end
            end
            if (!any_hit) begin
                n_vrow = vrow | free_oh;
            end
        end
        unique case (r_state)
            BK_READ: begin
                if (i_head.vld) begin
                    rd_en   = 1'b1;
                    n_state = BK_CMP;
                end
            end
            BK_CMP: begin
                if (out_free) begin
                    o_pop   = 1'b1;
                    wr_en   = (i_head.req.op == OP_SET) && (any_hit || any_free);
                    n_state = BK_READ;
                end
            end
            default: n_state = BK_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_READ;
            r_ovalid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (wr_en) begin
                r_valid[i_head.req.bucket] <= n_vrow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_head.req.bucket] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row <= mem[i_head.req.bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_found <= n_found;
            r_hop   <= n_hop;
            r_full  <= n_full;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.found       = r_found;
    assign o_rsp.next_hop    = r_hop;
    assign o_rsp.bucket_full = r_full;

endmodule

### hdl/hnht_checker.sv
// Port-level checker for the hashed next-hop table, bound to the top level.
// Depends on hnht_pkg for the field width and queue depth.
module hnht_checker
    import hnht_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_found,
    input logic [NODE_W-1:0] i_next_hop,
    input logic              i_bucket_full
);

    logic [3:0] r_open;
    logic       acc_in, acc_out;

    assign acc_in  = i_req_valid && i_req_ready;
    assign acc_out = i_rsp_valid && i_rsp_ready;

    // Requests taken whose results have not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (acc_in && !acc_out) begin
            r_open <= r_open + 1'b1;
        end else if (!acc_in && acc_out) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_open != '0))
        else $error("result shown with no request outstanding");

    a_bounded_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 4'(QDEPTH + 1))
        else $error("more requests outstanding than the block can hold");

    a_full_excludes_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_found && i_bucket_full))
        else $error("found and bucket_full both set");

    a_hop_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_next_hop != '0)) |-> i_found)
        else $error("next hop given without a hit");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_found) && $stable(i_next_hop)
             && $stable(i_bucket_full)))
        else $error("stalled result changed");

endmodule

bind hashed_next_hop_table_top hnht_checker u_hnht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_found       (o_rsp.found),
    .i_next_hop    (o_rsp.next_hop),
    .i_bucket_full (o_rsp.bucket_full)
);
